// ----- rtl/core/agcbgu_pkg.sv -----
// ----------------------------------------------------------------------------
// agcbgu_pkg
// Shared types, constants and dB tables for the AGC block gain update.
// ----------------------------------------------------------------------------
package agcbgu_pkg;

	localparam int unsigned NOISE_FLOOR_DEF = 128;

	localparam int unsigned GAIN_W = 16;
	localparam int unsigned PEAK_W = 16;
	localparam int unsigned DB_W = 5;
	localparam int unsigned SMOOTH_W = 11;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned Q_FRAC = 12;

	// shared divider: target numerator is a 15-bit peak shifted up by Q_FRAC
	localparam int unsigned DIVIDEND_W = 27;
	localparam int unsigned DIVISOR_W = 16;
	localparam int unsigned DIV_CNT_W = 5;

	localparam logic [GAIN_W-1:0] UNITY_Q12 = 16'd4096;
	localparam logic [GAIN_W-1:0] MIN_GAIN_Q12 = 16'd410;
	localparam logic [GAIN_W-1:0] MAX_GAIN_Q12 = 16'd40960;
	localparam logic [DB_W-1:0] ROM_LAST = 5'd20;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_BOOST = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_ATT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING = 2'd2;

	localparam logic [SMOOTH_W-1:0] SMOOTH_RST = 11'd100;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_TGT_START,
		ST_TGT_WAIT,
		ST_STEP_START,
		ST_STEP_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic                  busy;
		logic [DIVIDEND_W-1:0] quotient;
		logic [DIVISOR_W-1:0]  remainder;
	} div_rsp_t;

	// maximum gain, Q12, indexed by dB of boost (saturates at the last entry)
	function automatic logic [GAIN_W-1:0] gain_rom(input logic [DB_W-1:0] db);
		logic [GAIN_W-1:0] g;
		case (db)
			5'd0:    g = 16'd4096;
			5'd1:    g = 16'd4596;
			5'd2:    g = 16'd5157;
			5'd3:    g = 16'd5786;
			5'd4:    g = 16'd6492;
			5'd5:    g = 16'd7284;
			5'd6:    g = 16'd8173;
			5'd7:    g = 16'd9170;
			5'd8:    g = 16'd10289;
			5'd9:    g = 16'd11545;
			5'd10:   g = 16'd12953;
			5'd11:   g = 16'd14533;
			5'd12:   g = 16'd16307;
			5'd13:   g = 16'd18296;
			5'd14:   g = 16'd20529;
			5'd15:   g = 16'd23034;
			5'd16:   g = 16'd25844;
			5'd17:   g = 16'd28998;
			5'd18:   g = 16'd32535;
			5'd19:   g = 16'd36505;
			default: g = 16'd40960;
		endcase
		return g;
	endfunction

	// target peak level, indexed by dB below full scale
	function automatic logic [PEAK_W-2:0] peak_rom(input logic [DB_W-1:0] db);
		logic [PEAK_W-2:0] p;
		case (db)
			5'd0:    p = 15'd32767;
			5'd1:    p = 15'd29204;
			5'd2:    p = 15'd26028;
			5'd3:    p = 15'd23198;
			5'd4:    p = 15'd20675;
			5'd5:    p = 15'd18426;
			5'd6:    p = 15'd16422;
			5'd7:    p = 15'd14636;
			5'd8:    p = 15'd13045;
			5'd9:    p = 15'd11625;
			5'd10:   p = 15'd10362;
			5'd11:   p = 15'd9235;
			5'd12:   p = 15'd8231;
			5'd13:   p = 15'd7336;
			5'd14:   p = 15'd6538;
			5'd15:   p = 15'd5827;
			5'd16:   p = 15'd5193;
			5'd17:   p = 15'd4628;
			5'd18:   p = 15'd4125;
			5'd19:   p = 15'd3676;
			default: p = 15'd3277;
		endcase
		return p;
	endfunction

endpackage

// ----- rtl/core/agcbgu_div.sv -----
// ----------------------------------------------------------------------------
// agcbgu_div
// Restoring divider, one quotient bit per cycle, shared by both divisions.
// ----------------------------------------------------------------------------
module agcbgu_div (
	input  logic                clk,
	input  logic                arst_n,
	input  agcbgu_pkg::div_req_t req,
	output agcbgu_pkg::div_rsp_t rsp
);

	localparam int unsigned NW = agcbgu_pkg::DIVIDEND_W;
	localparam int unsigned DW = agcbgu_pkg::DIVISOR_W;
	localparam int unsigned CW = agcbgu_pkg::DIV_CNT_W;

	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          fits;

	assign trial = {rem_q, quo_q[NW-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.busy      = busy_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

`ifndef SYNTHESIS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");
	a_last_bit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q == '0 && !req.start) |=> done_q)
		else $error("divider missed done");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while busy");
`endif

endmodule

// ----- rtl/core/agc_block_gain_update_unit.sv -----
// ----------------------------------------------------------------------------
// agc_block_gain_update_unit
// Peak-based AGC: once-per-block target gain and smoothed Q12 gain update.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  s_*      in   s_tvalid / s_tready    tdata: block_peak, tuser: action
//  m_*      out  m_tvalid / m_tready    tdata: gain, target gain, tuser: gated
//  cfg_*    in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  a gain update makes two passes of the shared divider (target gain,
//  then the smoothing step) plus sequencer steps
//  a silent block skips the first pass, a reset action skips both
//  s_tready is high only while the sequencer is idle; the result register
//  frees the sequencer unless an earlier result is still waiting
//  cfg_ready is always high; reset gives unity gain and default registers
// ----------------------------------------------------------------------------
module agc_block_gain_update_unit #(
	parameter int unsigned NOISE_FLOOR = agcbgu_pkg::NOISE_FLOOR_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] block_peak
	input  logic        s_tuser,   // [0] action

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [15:0] gain_q12, [31:16] target_gain_q12
	output logic        m_tuser,   // [0] silence_gated

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);

	localparam int unsigned GW = agcbgu_pkg::GAIN_W;
	localparam int unsigned PW = agcbgu_pkg::PEAK_W;
	localparam int unsigned BW = agcbgu_pkg::DB_W;
	localparam int unsigned SW = agcbgu_pkg::SMOOTH_W;
	localparam int unsigned NW = agcbgu_pkg::DIVIDEND_W;
	localparam int unsigned DW = agcbgu_pkg::DIVISOR_W;
	localparam int unsigned QF = agcbgu_pkg::Q_FRAC;
	localparam logic [PW-1:0] FLOOR = PW'(NOISE_FLOOR);

	agcbgu_pkg::state_t   state_q, state_d;
	agcbgu_pkg::div_req_t div_req;
	agcbgu_pkg::div_rsp_t div_rsp;

	logic [BW-1:0] max_boost_q;
	logic [BW-1:0] target_att_q;
	logic [SW-1:0] smooth_q;
	logic [GW-1:0] gain_q;
	logic [GW-1:0] new_gain_q;
	logic [GW-1:0] target_q;
	logic          gated_q;
	logic          action_q;
	logic [PW-1:0] peak_q;

	logic          out_valid_q;
	logic [GW-1:0] out_gain_q;
	logic [GW-1:0] out_target_q;
	logic          out_gated_q;

	logic          in_req;
	logic          cfg_req;
	logic          out_free;
	logic          silent;
	logic [GW-1:0] top_gain;
	logic [GW-1:0] cfg_top;
	logic [GW-1:0] gain_diff;
	logic [SW-1:0] smooth_div;
	logic [NW-1:0] tgt_raw;
	logic [GW-1:0] tgt_clamped;
	logic [GW-1:0] step;

	assign cfg_ready = 1'b1;
	assign cfg_req   = cfg_valid && cfg_ready;
	assign in_req    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign silent    = (peak_q < FLOOR) || (peak_q == '0);
	assign top_gain  = agcbgu_pkg::gain_rom(max_boost_q);
	assign cfg_top   = agcbgu_pkg::gain_rom(cfg_data[BW-1:0]);
	assign gain_diff = (gain_q > target_q) ? (gain_q - target_q) : (target_q - gain_q);
	assign smooth_div = (smooth_q == '0) ? SW'(1) : smooth_q;

	assign tgt_raw = div_rsp.quotient;
	always_comb begin
		if (tgt_raw < NW'(agcbgu_pkg::MIN_GAIN_Q12)) begin
			tgt_clamped = agcbgu_pkg::MIN_GAIN_Q12;
		end else if (tgt_raw > NW'(top_gain)) begin
			tgt_clamped = top_gain;
		end else begin
			tgt_clamped = tgt_raw[GW-1:0];
		end
	end

	// ceiling of the quotient
	assign step = div_rsp.quotient[GW-1:0] + GW'(div_rsp.remainder != '0);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			agcbgu_pkg::ST_IDLE: begin
				if (in_req) state_d = agcbgu_pkg::ST_CHECK;
			end
			agcbgu_pkg::ST_CHECK: begin
				if (action_q) state_d = agcbgu_pkg::ST_DONE;
				else if (silent) state_d = agcbgu_pkg::ST_STEP_START;
				else state_d = agcbgu_pkg::ST_TGT_START;
			end
			agcbgu_pkg::ST_TGT_START: state_d = agcbgu_pkg::ST_TGT_WAIT;
			agcbgu_pkg::ST_TGT_WAIT: begin
				if (div_rsp.done) state_d = agcbgu_pkg::ST_STEP_START;
			end
			agcbgu_pkg::ST_STEP_START: state_d = agcbgu_pkg::ST_STEP_WAIT;
			agcbgu_pkg::ST_STEP_WAIT: begin
				if (div_rsp.done) state_d = agcbgu_pkg::ST_DONE;
			end
			agcbgu_pkg::ST_DONE: begin
				if (out_free) state_d = agcbgu_pkg::ST_IDLE;
			end
			default: state_d = agcbgu_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = {{(NW-GW){1'b0}}, gain_diff};
		div_req.divisor  = {{(DW-SW){1'b0}}, smooth_div};
		case (state_q)
			agcbgu_pkg::ST_IDLE: s_tready = 1'b1;
			agcbgu_pkg::ST_TGT_START: begin
				div_req.start    = 1'b1;
				div_req.dividend = NW'({agcbgu_pkg::peak_rom(target_att_q), {QF{1'b0}}});
				div_req.divisor  = peak_q;
			end
			agcbgu_pkg::ST_STEP_START: div_req.start = 1'b1;
			default: s_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= agcbgu_pkg::ST_IDLE;
			max_boost_q  <= '0;
			target_att_q <= '0;
			smooth_q     <= agcbgu_pkg::SMOOTH_RST;
			gain_q       <= agcbgu_pkg::UNITY_Q12;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_req) begin
				case (cfg_index)
					agcbgu_pkg::REG_MAX_BOOST: begin
						max_boost_q <= cfg_data[BW-1:0];
						if (gain_q > cfg_top) gain_q <= cfg_top;
					end
					agcbgu_pkg::REG_TARGET_ATT: target_att_q <= cfg_data[BW-1:0];
					agcbgu_pkg::REG_SMOOTHING: smooth_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == agcbgu_pkg::ST_DONE && out_free) begin
				gain_q      <= new_gain_q;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_req) begin
			action_q   <= s_tuser;
			peak_q     <= s_tdata;
			target_q   <= agcbgu_pkg::UNITY_Q12;
			new_gain_q <= agcbgu_pkg::UNITY_Q12;
			gated_q    <= 1'b0;
		end
		if (state_q == agcbgu_pkg::ST_CHECK && !action_q && silent) begin
			gated_q <= 1'b1;
		end
		if (state_q == agcbgu_pkg::ST_TGT_WAIT && div_rsp.done) begin
			target_q <= tgt_clamped;
		end
		if (state_q == agcbgu_pkg::ST_STEP_WAIT && div_rsp.done) begin
			new_gain_q <= (gain_q > target_q) ? (gain_q - step) : (gain_q + step);
		end
		if (state_q == agcbgu_pkg::ST_DONE && out_free) begin
			out_gain_q   <= new_gain_q;
			out_target_q <= target_q;
			out_gated_q  <= gated_q;
		end
	end

	agcbgu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_target_q, out_gain_q};
	assign m_tuser  = out_gated_q;

`ifndef SYNTHESIS
	a_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == agcbgu_pkg::ST_TGT_WAIT ||
			state_q == agcbgu_pkg::ST_STEP_WAIT))
		else $error("divider result outside a wait state");
	a_busy_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.busy |-> (state_q == agcbgu_pkg::ST_TGT_WAIT ||
			state_q == agcbgu_pkg::ST_STEP_WAIT))
		else $error("divider busy outside a wait state");
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		gain_q >= agcbgu_pkg::MIN_GAIN_Q12 && gain_q <= agcbgu_pkg::MAX_GAIN_Q12)
		else $error("gain out of range");
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_req |=> !s_tready)
		else $error("second request taken while busy");
	a_gated_unity: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tdata[31:16] == agcbgu_pkg::UNITY_Q12)
		else $error("gated block without unity target");
`endif

endmodule

// ----- verif/tb_agc_block_gain_update_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_agc_block_gain_update_unit
// Self-checking bench for the AGC block gain update. Block requests are
// driven on the slave stream and register writes on the config channel.
// A scoreboard predicts the target gain, the silence flag and the smoothed
// Q12 gain, then compares every result on the master stream in order.
// Directed corner cases come first, then randomised phases with random
// settings, random source gaps and random sink back-pressure.
// ----------------------------------------------------------------------------
module tb_agc_block_gain_update_unit;

	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned RANDOM_PHASES = 14;
	localparam int unsigned PHASE_BLOCKS = 50;
	localparam int unsigned SETTLE_CYCLES = 100;
	localparam logic [agcbgu_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam logic [agcbgu_pkg::GAIN_W-1:0] BOOST_TABLE [21] = '{
		16'd4096, 16'd4596, 16'd5157, 16'd5786, 16'd6492, 16'd7284, 16'd8173,
		16'd9170, 16'd10289, 16'd11545, 16'd12953, 16'd14533, 16'd16307,
		16'd18296, 16'd20529, 16'd23034, 16'd25844, 16'd28998, 16'd32535,
		16'd36505, 16'd40960
	};

	localparam logic [agcbgu_pkg::PEAK_W-1:0] LEVEL_TABLE [21] = '{
		16'd32767, 16'd29204, 16'd26028, 16'd23198, 16'd20675, 16'd18426,
		16'd16422, 16'd14636, 16'd13045, 16'd11625, 16'd10362, 16'd9235,
		16'd8231, 16'd7336, 16'd6538, 16'd5827, 16'd5193, 16'd4628,
		16'd4125, 16'd3676, 16'd3277
	};

	typedef struct packed {
		logic [agcbgu_pkg::GAIN_W-1:0] gain;
		logic [agcbgu_pkg::GAIN_W-1:0] target;
		logic                          gated;
	} gain_result_t;

	class gain_scoreboard;
		logic [agcbgu_pkg::DB_W-1:0]     boost_db;
		logic [agcbgu_pkg::DB_W-1:0]     atten_db;
		logic [agcbgu_pkg::SMOOTH_W-1:0] smooth_div;
		logic [agcbgu_pkg::GAIN_W-1:0]   gain_now;
		gain_result_t                    pending_gains[$];
		int                              errors;

		function new();
			boost_db = '0;
			atten_db = '0;
			smooth_div = agcbgu_pkg::SMOOTH_RST;
			gain_now = agcbgu_pkg::UNITY_Q12;
			errors = 0;
		endfunction

		function int unsigned db_slot(logic [agcbgu_pkg::DB_W-1:0] db);
			return (db > agcbgu_pkg::ROM_LAST) ? int'(agcbgu_pkg::ROM_LAST) : int'(db);
		endfunction

		function logic [agcbgu_pkg::GAIN_W-1:0] top_gain();
			return BOOST_TABLE[db_slot(boost_db)];
		endfunction

		function void apply_reg(logic [agcbgu_pkg::CFG_IDX_W-1:0] idx,
			logic [agcbgu_pkg::SMOOTH_W-1:0] data);
			case (idx)
				agcbgu_pkg::REG_MAX_BOOST: begin
					boost_db = data[agcbgu_pkg::DB_W-1:0];
					if (gain_now > top_gain())
						gain_now = top_gain();
				end
				agcbgu_pkg::REG_TARGET_ATT: atten_db = data[agcbgu_pkg::DB_W-1:0];
				agcbgu_pkg::REG_SMOOTHING: smooth_div = data;
				default: ;
			endcase
		endfunction

		function void note_block(logic act, logic [agcbgu_pkg::PEAK_W-1:0] peak);
			gain_result_t r;
			logic [31:0] goal;
			logic [31:0] diff;
			logic [31:0] div;
			logic [31:0] stride;
			r.target = agcbgu_pkg::UNITY_Q12;
			r.gated = 1'b0;
			if (act) begin
				gain_now = agcbgu_pkg::UNITY_Q12;
			end else begin
				if (32'(peak) < agcbgu_pkg::NOISE_FLOOR_DEF) begin
					r.gated = 1'b1;
				end else begin
					goal = (32'(LEVEL_TABLE[db_slot(atten_db)]) * 32'd4096) / 32'(peak);
					if (goal < 32'(agcbgu_pkg::MIN_GAIN_Q12))
						goal = 32'(agcbgu_pkg::MIN_GAIN_Q12);
					if (goal > 32'(top_gain()))
						goal = 32'(top_gain());
					r.target = goal[agcbgu_pkg::GAIN_W-1:0];
				end
				div = (smooth_div == '0) ? 32'd1 : 32'(smooth_div);
				if (gain_now != r.target) begin
					diff = (gain_now > r.target) ? 32'(gain_now - r.target)
						: 32'(r.target - gain_now);
					stride = (diff + div - 32'd1) / div;
					if (gain_now > r.target)
						gain_now = gain_now - stride[agcbgu_pkg::GAIN_W-1:0];
					else
						gain_now = gain_now + stride[agcbgu_pkg::GAIN_W-1:0];
				end
			end
			r.gain = gain_now;
			pending_gains.push_back(r);
		endfunction

		function void check_result(logic [31:0] tdata, logic tuser);
			gain_result_t want;
			if (pending_gains.size() == 0) begin
				$display("%0t: unexpected result gain %0d target %0d gated %0d",
					$time, tdata[15:0], tdata[31:16], tuser);
				errors++;
				return;
			end
			want = pending_gains.pop_front();
			if (tdata[15:0] !== want.gain) begin
				$display("%0t: gain_q12 expected %0d actual %0d", $time, want.gain, tdata[15:0]);
				errors++;
			end
			if (tdata[31:16] !== want.target) begin
				$display("%0t: target_gain_q12 expected %0d actual %0d",
					$time, want.target, tdata[31:16]);
				errors++;
			end
			if (tuser !== want.gated) begin
				$display("%0t: silence_gated expected %0d actual %0d", $time, want.gated, tuser);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [10:0] cfg_data;

	gain_scoreboard sb = new();
	bit             calm_phase;
	int unsigned    cycle_count;

	agc_block_gain_update_unit #(
		.NOISE_FLOOR(agcbgu_pkg::NOISE_FLOOR_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm_phase || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_block(input logic act, input logic [15:0] peak);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= peak;
		s_tuser <= act;
		do @(posedge clk); while (!s_tready);
		sb.note_block(act, peak);
	endtask

	task automatic stop_blocks();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	// block is idle once every result is out
	task automatic drain_results();
		while (sb.pending_gains.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [10:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.apply_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_settings();
		int r;
		logic [10:0] v;
		r = $urandom_range(0, 9);
		v = (r < 6) ? 11'($urandom_range(0, 20)) : (r < 8) ? (r[0] ? 11'd20 : 11'd0)
			: 11'($urandom);
		write_reg(agcbgu_pkg::REG_MAX_BOOST, v);
		r = $urandom_range(0, 9);
		v = (r < 6) ? 11'($urandom_range(0, 20)) : (r < 8) ? (r[0] ? 11'd20 : 11'd0)
			: 11'($urandom);
		write_reg(agcbgu_pkg::REG_TARGET_ATT, v);
		r = $urandom_range(0, 9);
		if (r < 5)
			v = 11'($urandom_range(1, 8));
		else if (r < 7)
			v = 11'($urandom_range(9, 1024));
		else if (r == 7)
			v = $urandom_range(0, 1) ? 11'd1024 : 11'd1;
		else if (r == 8)
			v = 11'd0;
		else
			v = 11'($urandom);
		write_reg(agcbgu_pkg::REG_SMOOTHING, v);
		if ($urandom_range(0, 4) == 0)
			write_reg(REG_UNUSED, 11'($urandom));
	endtask

	task automatic random_block();
		int r;
		logic act;
		logic [15:0] peak;
		act = ($urandom_range(0, 99) < 5);
		r = $urandom_range(0, 99);
		if (r < 15)
			peak = 16'($urandom_range(0, 127));
		else if (r < 65)
			peak = 16'($urandom_range(128, 32768));
		else if (r < 85)
			peak = 16'($urandom);
		else
			case ($urandom_range(0, 5))
				0: peak = 16'd0;
				1: peak = 16'd127;
				2: peak = 16'd128;
				3: peak = 16'd32767;
				4: peak = 16'd32768;
				default: peak = 16'hffff;
			endcase
		send_block(act, peak);
	endtask

	// result sink with random back-pressure
	initial begin
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				sb.check_result(m_tdata, m_tuser);
			@(negedge clk);
			if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				stall = pick_gap();
				m_tready <= (stall == 0);
				if (stall > 0)
					stall--;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm_phase = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// defaults: silence, floor edge, full scale, oversize peaks, reset action
		send_block(1'b1, 16'd0);
		send_block(1'b0, 16'd0);
		send_block(1'b0, 16'd127);
		send_block(1'b0, 16'd128);
		send_block(1'b0, 16'd32767);
		send_block(1'b0, 16'd32768);
		send_block(1'b0, 16'hffff);
		send_block(1'b1, 16'hffff);
		stop_blocks();
		drain_results();

		// instant step, top boost, deepest target: both clamps
		write_reg(agcbgu_pkg::REG_SMOOTHING, 11'd1);
		write_reg(agcbgu_pkg::REG_MAX_BOOST, 11'd20);
		write_reg(agcbgu_pkg::REG_TARGET_ATT, 11'd20);
		send_block(1'b0, 16'd128);
		send_block(1'b0, 16'hffff);
		send_block(1'b0, 16'd1000);
		stop_blocks();
		drain_results();

		// saturating rom indexes, zero divisor
		write_reg(agcbgu_pkg::REG_MAX_BOOST, 11'd31);
		write_reg(agcbgu_pkg::REG_SMOOTHING, 11'd0);
		write_reg(agcbgu_pkg::REG_TARGET_ATT, 11'd31);
		send_block(1'b0, 16'd200);
		stop_blocks();
		drain_results();

		// lowering the boost clamps the held gain, unused index ignored
		write_reg(agcbgu_pkg::REG_MAX_BOOST, 11'd0);
		write_reg(REG_UNUSED, 11'h7ff);
		write_reg(agcbgu_pkg::REG_SMOOTHING, 11'h7ff);
		send_block(1'b0, 16'h5555);
		send_block(1'b0, 16'haaaa);
		send_block(1'b0, 16'd130);
		stop_blocks();
		drain_results();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			random_settings();
			calm_phase = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < PHASE_BLOCKS; i++)
				random_block();
			stop_blocks();
			drain_results();
			calm_phase = 1'b0;
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending_gains.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/agcbgu_pkg.sv
rtl/core/agcbgu_div.sv
rtl/core/agc_block_gain_update_unit.sv
verif/tb_agc_block_gain_update_unit.sv
